[rtl/mavlink_frame_validator_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the MAVLink frame validator
// Shared concurrent assertion forms, clocked on i_clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef MAVLINK_FRAME_VALIDATOR_UNIT_ASSERT_SVH
`define MAVLINK_FRAME_VALIDATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define MFV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MFV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mfv_pkg.sv]
// ----------------------------------------------------------------------------
// MAVLink frame validator package
// Frame constants, parser phase type, result bundle, CRC step and message seed ROM.
// ----------------------------------------------------------------------------
package mfv_pkg;

    localparam logic [7:0]  START_V2 = 8'hFD;
    localparam logic [7:0]  START_V1 = 8'hFE;
    localparam logic [8:0]  EXTRA_V2 = 9'd10;   // header 8 + CRC 2
    localparam logic [8:0]  EXTRA_V1 = 9'd6;    // header 4 + CRC 2
    localparam logic [23:0] ID_LIMIT = 24'd255;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    typedef struct packed {
        logic        in_frame;
        logic [8:0]  byte_position;
        logic        frame_end;
        logic        crc_good;
        logic        packet_valid;
        logic [8:0]  packet_length;
        logic [23:0] message_id;
    } t_result;

    localparam logic [7:0] EXTRA_ROM [0:255] = '{
        8'd50,  8'd124, 8'd137, 8'd0,   8'd237, 8'd217, 8'd104, 8'd119,
        8'd0,   8'd0,   8'd0,   8'd89,  8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd214, 8'd159, 8'd220, 8'd168,
        8'd24,  8'd23,  8'd170, 8'd144, 8'd67,  8'd115, 8'd39,  8'd246,
        8'd185, 8'd104, 8'd237, 8'd244, 8'd222, 8'd212, 8'd9,   8'd254,
        8'd230, 8'd28,  8'd28,  8'd132, 8'd221, 8'd232, 8'd11,  8'd153,
        8'd41,  8'd39,  8'd78,  8'd196, 8'd0,   8'd0,   8'd15,  8'd3,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd167, 8'd183, 8'd119,
        8'd191, 8'd118, 8'd148, 8'd21,  8'd0,   8'd243, 8'd124, 8'd0,
        8'd0,   8'd38,  8'd20,  8'd158, 8'd152, 8'd143, 8'd0,   8'd0,
        8'd0,   8'd106, 8'd49,  8'd22,  8'd143, 8'd140, 8'd5,   8'd150,
        8'd0,   8'd231, 8'd183, 8'd63,  8'd54,  8'd47,  8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd175, 8'd102, 8'd158, 8'd208,
        8'd56,  8'd93,  8'd138, 8'd108, 8'd32,  8'd185, 8'd84,  8'd34,
        8'd174, 8'd124, 8'd237, 8'd4,   8'd76,  8'd128, 8'd56,  8'd116,
        8'd134, 8'd237, 8'd203, 8'd250, 8'd87,  8'd203, 8'd220, 8'd25,
        8'd226, 8'd46,  8'd29,  8'd223, 8'd85,  8'd6,   8'd229, 8'd203,
        8'd1,   8'd195, 8'd109, 8'd168, 8'd181, 8'd47,  8'd72,  8'd131,
        8'd127, 8'd0,   8'd103, 8'd154, 8'd178, 8'd200, 8'd134, 8'd219,
        8'd208, 8'd188, 8'd84,  8'd22,  8'd19,  8'd21,  8'd134, 8'd0,
        8'd78,  8'd68,  8'd189, 8'd127, 8'd154, 8'd21,  8'd21,  8'd144,
        8'd1,   8'd234, 8'd73,  8'd181, 8'd22,  8'd83,  8'd167, 8'd138,
        8'd234, 8'd240, 8'd47,  8'd189, 8'd52,  8'd174, 8'd229, 8'd85,
        8'd159, 8'd186, 8'd72,  8'd0,   8'd0,   8'd0,   8'd0,   8'd92,
        8'd36,  8'd71,  8'd98,  8'd120, 8'd0,   8'd0,   8'd0,   8'd0,
        8'd134, 8'd205, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd69,  8'd101, 8'd50,  8'd202, 8'd17,  8'd162, 8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd207, 8'd0,   8'd0,   8'd0,
        8'd163, 8'd105, 8'd151, 8'd35,  8'd150, 8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd90,  8'd104, 8'd85,  8'd95,  8'd130,
        8'd184, 8'd81,  8'd8,   8'd204, 8'd49,  8'd170, 8'd44,  8'd83
    };

    // One byte of CRC-16/MCRF4XX (reflected 0x1021)
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
        logic [7:0] t;
        t = data ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000}
               ^ {12'h000, t[7:4]};
    endfunction

endpackage

[rtl/mfv_in_stage.sv]
// ----------------------------------------------------------------------------
// MAVLink frame validator input stage
// Registers one received byte and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module mfv_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       w_load;

    // free when empty or when the held byte leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

[rtl/mfv_parser.sv]
// ----------------------------------------------------------------------------
// MAVLink frame parser
// Frame state, running CRC, id capture and per-byte status in one step.
// ----------------------------------------------------------------------------
`include "mavlink_frame_validator_unit_assert.svh"

module mfv_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_byte,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic            i_cfg_data,
    output mfv_pkg::t_result o_result
);

    mfv_pkg::t_phase r_phase;
    mfv_pkg::t_phase n_phase;
    logic        r_v2_mode;
    logic [8:0]  r_write_index, n_write_index;
    logic [8:0]  r_bytes_left,  n_bytes_left;
    logic [15:0] r_crc,         n_crc;
    logic [7:0]  r_crc_low,     n_crc_low;
    logic [23:0] r_id,          n_id;
    logic        r_got,         n_got;

    logic [8:0]  w_left_dec;
    logic        w_start;
    logic [7:0]  w_extra;
    logic [15:0] w_final;
    logic        w_end_step;
    logic        w_in_len;

    assign o_cfg_ready = 1'b1;
    assign w_left_dec  = r_bytes_left - 9'd1;
    assign w_start     = (i_byte == (r_v2_mode ? mfv_pkg::START_V2 : mfv_pkg::START_V1));

    // next phase
    always_comb begin
        case (r_phase)
            mfv_pkg::PH_LEN: begin
                n_phase = mfv_pkg::PH_BODY;
            end
            mfv_pkg::PH_BODY: begin
                n_phase = (w_left_dec == 9'd0) ? mfv_pkg::PH_IDLE : mfv_pkg::PH_BODY;
            end
            default: begin
                n_phase = w_start ? mfv_pkg::PH_LEN : mfv_pkg::PH_IDLE;
            end
        endcase
    end

    // datapath and result
    always_comb begin
        n_write_index = r_write_index;
        n_bytes_left  = r_bytes_left;
        n_crc         = r_crc;
        n_crc_low     = r_crc_low;
        n_id          = r_id;
        n_got         = r_got;
        w_extra       = 8'h00;
        w_final       = 16'h0000;
        o_result.in_frame      = 1'b0;
        o_result.byte_position = 9'd0;
        o_result.frame_end     = 1'b0;
        o_result.crc_good      = 1'b0;

        case (r_phase)
            mfv_pkg::PH_LEN: begin
                o_result.in_frame      = 1'b1;
                o_result.byte_position = 9'd1;
                n_crc         = mfv_pkg::crc_step(mfv_pkg::CRC_INIT, i_byte);
                n_write_index = 9'd2;
                n_bytes_left  = {1'b0, i_byte}
                              + (r_v2_mode ? mfv_pkg::EXTRA_V2 : mfv_pkg::EXTRA_V1);
            end
            mfv_pkg::PH_BODY: begin
                o_result.in_frame      = 1'b1;
                o_result.byte_position = r_write_index;
                // capture the message id as its bytes pass
                if (r_v2_mode) begin
                    if (r_write_index == 9'd7) begin
                        n_id = {16'h0000, i_byte};
                    end else if (r_write_index == 9'd8) begin
                        n_id = {r_id[23:16], i_byte, r_id[7:0]};
                    end else if (r_write_index == 9'd9) begin
                        n_id = {i_byte, r_id[15:0]};
                    end
                end else if (r_write_index == 9'd5) begin
                    n_id = {16'h0000, i_byte};
                end
                n_write_index = r_write_index + 9'd1;
                n_bytes_left  = w_left_dec;
                if (w_left_dec >= 9'd2) begin
                    n_crc = mfv_pkg::crc_step(r_crc, i_byte);
                end else if (w_left_dec == 9'd1) begin
                    n_crc_low = i_byte;
                end else begin
                    // fold in the message seed byte, then check against the received CRC
                    w_extra = (n_id < mfv_pkg::ID_LIMIT) ? mfv_pkg::EXTRA_ROM[n_id[7:0]] : 8'h00;
                    w_final = mfv_pkg::crc_step(r_crc, w_extra);
                    o_result.frame_end = 1'b1;
                    o_result.crc_good  = (w_final == {i_byte, r_crc_low});
                    if (w_final == {i_byte, r_crc_low}) begin
                        n_got = 1'b1;
                    end
                end
            end
            default: begin
                if (w_start) begin
                    o_result.in_frame = 1'b1;
                    n_got         = 1'b0;
                    n_write_index = 9'd1;
                end
            end
        endcase

        o_result.packet_valid  = n_got;
        o_result.packet_length = n_got ? n_write_index : 9'd0;
        o_result.message_id    = n_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2_mode <= 1'b1;
        end else if (i_cfg_valid) begin
            r_v2_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= mfv_pkg::PH_IDLE;
            r_write_index <= 9'd0;
            r_bytes_left  <= 9'd0;
            r_crc         <= mfv_pkg::CRC_INIT;
            r_crc_low     <= 8'h00;
            r_id          <= 24'h000000;
            r_got         <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_write_index <= n_write_index;
            r_bytes_left  <= n_bytes_left;
            r_crc         <= n_crc;
            r_crc_low     <= n_crc_low;
            r_id          <= n_id;
            r_got         <= n_got;
        end
    end

    assign w_end_step = i_step && o_result.frame_end;
    assign w_in_len   = (r_phase == mfv_pkg::PH_LEN);

    `MFV_ASSERT_SAME(a_end_in_frame, w_end_step, o_result.in_frame, "end outside a frame")
    `MFV_ASSERT_SAME(a_good_at_end, o_result.crc_good, o_result.frame_end, "good without end")
    `MFV_ASSERT_NEXT(a_end_to_idle, w_end_step, r_phase == mfv_pkg::PH_IDLE, "no idle after end")
    `MFV_ASSERT_SAME(a_len_pos, w_in_len, o_result.byte_position == 9'd1, "bad length position")

endmodule

[rtl/mfv_out_stage.sv]
// ----------------------------------------------------------------------------
// MAVLink frame validator output stage
// Result register; takes a new result whenever it is empty or being drained.
// ----------------------------------------------------------------------------
module mfv_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  mfv_pkg::t_result i_result,
    output logic             o_take,
    output logic             o_valid,
    input  logic             i_ready,
    output mfv_pkg::t_result o_result
);

    logic             r_valid;
    logic             n_valid;
    mfv_pkg::t_result r_result;

    assign o_take = i_valid && (!r_valid || i_ready);

    always_comb begin
        n_valid = r_valid;
        if (o_take) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[rtl/mavlink_frame_validator_unit.sv]
// A result passes the input register, then the result register, before it is offered.
// Throughput: one byte per cycle while results drain; CRC-16 and frame-counter updates are combinational.
// A result held back lets one more byte in, then the input stalls.
// Reset: synchronous, active low; idle phase, CRC 0xFFFF, v2 framing, both stages empty.
// ----------------------------------------------------------------------------
// MAVLink frame validator
// Byte-stream framer with v1/v2 start detection and CRC-16/MCRF4XX check.
// ----------------------------------------------------------------------------
module mavlink_frame_validator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_in_frame,
    output logic [8:0]  o_byte_position,
    output logic        o_frame_end,
    output logic        o_crc_good,
    output logic        o_packet_valid,
    output logic [8:0]  o_packet_length,
    output logic [23:0] o_message_id,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    logic             w_take;
    logic             w_byte_valid;
    logic [7:0]       w_byte;
    mfv_pkg::t_result w_step_result;
    mfv_pkg::t_result w_out_result;

    mfv_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .i_take    (w_take),
        .o_valid   (w_byte_valid),
        .o_byte    (w_byte)
    );

    mfv_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_take),
        .i_byte      (w_byte),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_result    (w_step_result)
    );

    mfv_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_byte_valid),
        .i_result (w_step_result),
        .o_take   (w_take),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (w_out_result)
    );

    assign o_in_frame      = w_out_result.in_frame;
    assign o_byte_position = w_out_result.byte_position;
    assign o_frame_end     = w_out_result.frame_end;
    assign o_crc_good      = w_out_result.crc_good;
    assign o_packet_valid  = w_out_result.packet_valid;
    assign o_packet_length = w_out_result.packet_length;
    assign o_message_id    = w_out_result.message_id;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MAVLink frame validator testbench
// Feeds v1 and v2 byte streams through the validator and checks every result.
// The stream holds well-formed frames with random headers, payloads and ids,
// frames with a corrupted CRC, cut-off frames, stray bytes and frames in the
// other framing. Framing is switched between bursts of traffic, also in the
// middle of a frame. Both handshakes idle at random.
// ----------------------------------------------------------------------------

class frame_scoreboard;
    bit                     mode_v2     = 1'b1;
    mfv_pkg::t_phase        parse_phase = mfv_pkg::PH_IDLE;
    logic [8:0]             frame_idx   = '0;
    logic [8:0]             left_count  = '0;
    logic [15:0]            crc_acc     = mfv_pkg::CRC_INIT;
    logic [7:0]             crc_lo      = '0;
    logic [23:0]            id_reg      = '0;
    bit                     pkt_ok      = 1'b0;
    mfv_pkg::t_result       expected_q[$];
    int unsigned            errors;
    int unsigned            checked;
    int unsigned            good_frames;
    int unsigned            bad_frames;

    // Bit-serial CRC-16/MCRF4XX, reflected polynomial
    static function logic [15:0] crc_x25(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        int          k;
        c = crc ^ {8'h00, d};
        for (k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
        end
        return c;
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    // Advance the framer by one accepted byte and queue the result it gives
    function void note_rx_byte(input logic [7:0] b);
        mfv_pkg::t_result r;
        logic [7:0]       extra;
        logic [15:0]      fin;
        r = '0;
        case (parse_phase)
            mfv_pkg::PH_LEN: begin
                r.in_frame      = 1'b1;
                r.byte_position = 9'd1;
                crc_acc         = crc_x25(mfv_pkg::CRC_INIT, b);
                frame_idx       = 9'd2;
                left_count      = {1'b0, b} + (mode_v2 ? mfv_pkg::EXTRA_V2 : mfv_pkg::EXTRA_V1);
                parse_phase     = mfv_pkg::PH_BODY;
            end
            mfv_pkg::PH_BODY: begin
                r.in_frame      = 1'b1;
                r.byte_position = frame_idx;
                if (mode_v2) begin
                    if (frame_idx == 9'd7) id_reg = {16'h0000, b};
                    else if (frame_idx == 9'd8) id_reg[15:8] = b;
                    else if (frame_idx == 9'd9) id_reg[23:16] = b;
                end else if (frame_idx == 9'd5) begin
                    id_reg = {16'h0000, b};
                end
                frame_idx  = frame_idx + 9'd1;
                left_count = left_count - 9'd1;
                if (left_count >= 9'd2) begin
                    crc_acc = crc_x25(crc_acc, b);
                end else if (left_count == 9'd1) begin
                    crc_lo = b;
                end else begin
                    // the seed byte only exists for ids inside the table
                    extra       = (id_reg < mfv_pkg::ID_LIMIT) ? mfv_pkg::EXTRA_ROM[id_reg[7:0]]
                                                               : 8'h00;
                    fin         = crc_x25(crc_acc, extra);
                    r.frame_end = 1'b1;
                    r.crc_good  = (fin == {b, crc_lo});
                    if (r.crc_good) pkt_ok = 1'b1;
                    parse_phase = mfv_pkg::PH_IDLE;
                end
            end
            default: begin
                parse_phase = mfv_pkg::PH_IDLE;
                if (b == (mode_v2 ? mfv_pkg::START_V2 : mfv_pkg::START_V1)) begin
                    r.in_frame  = 1'b1;
                    pkt_ok      = 1'b0;
                    frame_idx   = 9'd1;
                    parse_phase = mfv_pkg::PH_LEN;
                end
            end
        endcase
        r.packet_valid  = pkt_ok;
        r.packet_length = pkt_ok ? frame_idx : 9'd0;
        r.message_id    = id_reg;
        expected_q.push_back(r);
    endfunction

    function void check_result(input mfv_pkg::t_result got);
        mfv_pkg::t_result want;
        bit               bad;
        checked++;
        if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("%0t: result %h arrived with nothing pending", $time, got);
            return;
        end
        want = expected_q.pop_front();
        bad = (got.in_frame !== want.in_frame) || (got.byte_position !== want.byte_position)
              || (got.frame_end !== want.frame_end) || (got.crc_good !== want.crc_good)
              || (got.packet_valid !== want.packet_valid)
              || (got.packet_length !== want.packet_length)
              || (got.message_id !== want.message_id);
        if (bad) begin
            errors++;
            if (errors <= 10) begin
                $display("%0t: result %0d mismatch", $time, checked);
                $display("  expected fr=%b pos=%0d end=%b good=%b pv=%b len=%0d id=%h",
                         want.in_frame, want.byte_position, want.frame_end, want.crc_good,
                         want.packet_valid, want.packet_length, want.message_id);
                $display("  actual   fr=%b pos=%0d end=%b good=%b pv=%b len=%0d id=%h",
                         got.in_frame, got.byte_position, got.frame_end, got.crc_good,
                         got.packet_valid, got.packet_length, got.message_id);
            end
        end
        if (want.frame_end) begin
            if (want.crc_good) good_frames++;
            else bad_frames++;
        end
    endfunction
endclass

module tb_top;

    localparam int unsigned STALL_LIMIT = 5000;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    logic        o_in_frame;
    logic [8:0]  o_byte_position;
    logic        o_frame_end;
    logic        o_crc_good;
    logic        o_packet_valid;
    logic [8:0]  o_packet_length;
    logic [23:0] o_message_id;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data  = 1'b0;

    frame_scoreboard sb = new;

    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned sink_hold    = 0;
    int unsigned bytes_sent   = 0;
    int unsigned cfg_writes   = 0;
    int unsigned quiet_cycles = 0;
    bit          cur_v2       = 1'b1;

    mavlink_frame_validator_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_in_frame      (o_in_frame),
        .o_byte_position (o_byte_position),
        .o_frame_end     (o_frame_end),
        .o_crc_good      (o_crc_good),
        .o_packet_valid  (o_packet_valid),
        .o_packet_length (o_packet_length),
        .o_message_id    (o_message_id),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: take a transfer, then pick next cycle's ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result({o_in_frame, o_byte_position, o_frame_end, o_crc_good,
                             o_packet_valid, o_packet_length, o_message_id});
        end
        if (sink_hold > 0) begin
            sink_hold--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        sb.note_rx_byte(b);
        bytes_sent++;
    endtask

    // Hold the input back until every result has been taken
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic switch_framing(input bit v2);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v2;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.mode_v2 = v2;
        cur_v2     = v2;
        cfg_writes++;
    endtask

    task automatic send_noise(input int unsigned n);
        repeat (n) send_byte(8'($urandom));
    endtask

    // Build a frame with its proper CRC, or one bit flipped when bad_crc is set; cut > 0 stops after that many bytes
    task automatic send_frame(input bit v2, input int unsigned plen, input logic [23:0] msg_id,
                              input bit bad_crc, input int unsigned cut);
        logic [7:0]  fb[$];
        logic [15:0] crc;
        logic [23:0] id_seen;
        int unsigned k;
        int unsigned n;
        fb.push_back(v2 ? mfv_pkg::START_V2 : mfv_pkg::START_V1);
        fb.push_back(plen[7:0]);
        if (v2) begin
            repeat (5) fb.push_back(8'($urandom));
            fb.push_back(msg_id[7:0]);
            fb.push_back(msg_id[15:8]);
            fb.push_back(msg_id[23:16]);
            id_seen = msg_id;
        end else begin
            repeat (3) fb.push_back(8'($urandom));
            fb.push_back(msg_id[7:0]);
            id_seen = {16'h0000, msg_id[7:0]};
        end
        repeat (plen) fb.push_back(8'($urandom));
        crc = mfv_pkg::CRC_INIT;
        for (k = 1; k < fb.size(); k++) crc = sb.crc_x25(crc, fb[k]);
        crc = sb.crc_x25(crc, (id_seen < mfv_pkg::ID_LIMIT)
                              ? mfv_pkg::EXTRA_ROM[id_seen[7:0]] : 8'h00);
        if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(15));
        fb.push_back(crc[7:0]);
        fb.push_back(crc[15:8]);
        n = (cut == 0 || cut > fb.size()) ? fb.size() : cut;
        for (k = 0; k < n; k++) send_byte(fb[k]);
    endtask

    function automatic logic [23:0] pick_msg_id();
        case ($urandom_range(9))
            0:       return 24'($urandom);
            1:       return mfv_pkg::ID_LIMIT + 24'($urandom_range(3));
            default: return 24'($urandom_range(254));
        endcase
    endfunction

    // Mostly short payloads, now and then a long one
    function automatic int unsigned pick_len();
        if ($urandom_range(99) < 3) return $urandom_range(200, 255);
        return $urandom_range(24);
    endfunction

    task automatic run_traffic(input int unsigned n_bytes);
        int unsigned stop_at;
        int unsigned next_flip;
        int unsigned pick;
        stop_at   = bytes_sent + n_bytes;
        next_flip = bytes_sent + $urandom_range(120, 200);
        while (bytes_sent < stop_at) begin
            if (bytes_sent >= next_flip) begin
                switch_framing(!cur_v2);
                next_flip = bytes_sent + $urandom_range(120, 200);
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_frame(cur_v2, pick_len(), pick_msg_id(), 1'b0, 0);
            end else if (pick < 80) begin
                send_frame(cur_v2, pick_len(), pick_msg_id(), 1'b1, 0);
            end else if (pick < 88) begin
                send_frame(cur_v2, $urandom_range(24), pick_msg_id(), 1'b0,
                           $urandom_range(1, 8));
                send_noise($urandom_range(1, 4));
            end else if (pick < 95) begin
                send_noise($urandom_range(1, 6));
            end else begin
                send_frame(!cur_v2, $urandom_range(24), pick_msg_id(), 1'b0, 0);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: byte extremes, id above the table, framing switched mid-frame
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(1'b1, 0, 24'hFFFFFF, 1'b0, 0);
        switch_framing(1'b0);
        send_byte(mfv_pkg::START_V1);
        send_byte(8'h00);
        send_noise(3);
        switch_framing(1'b1);
        send_noise(3);

        src_idle_pct = 8;
        snk_idle_pct = 87;
        run_traffic(300);

        src_idle_pct = 87;
        snk_idle_pct = 8;
        run_traffic(300);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        switch_framing(1'b1);
        send_frame(1'b1, 255, pick_msg_id(), 1'b0, 0);
        switch_framing(1'b0);
        send_frame(1'b0, 255, 24'($urandom_range(254)), 1'b0, 0);
        // Starve the result side so the input has to stall
        sink_hold = 60;
        send_frame(cur_v2, 40, pick_msg_id(), 1'b0, 0);
        run_traffic(200);

        drain_results();
        repeat (10) @(posedge i_clk);

        $display("covered %0d bytes and %0d framing writes in both v1 and v2 framing",
                 bytes_sent, cfg_writes);
        $display("frames ended: %0d with good CRC, %0d with bad CRC; %0d mismatches",
                 sb.good_frames, sb.bad_frames, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule
